// ===== design/assert_macros.svh =====
// Assertion macros shared by the Sobel edge block.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on i_clk and disabled while reset is held.
`define SOBEL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Asserts that a condition never occurs.
`define SOBEL_ASSERT_NEVER(lbl, expr, msg) \
    `SOBEL_ASSERT(lbl, !(expr), msg)

`endif

// ===== design/sobel_pkg.sv =====
// Package for the Sobel edge magnitude block: beat types and constants.
// Depends on nothing.
package sobel_pkg;

    localparam int DEFAULT_MAX_LINE_WIDTH = 8192;
    localparam int LINE_WIDTH_W           = 14;
    localparam int OUT_COL_W              = 13;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 14'd5000;

    typedef logic [7:0]           t_pix;
    typedef logic [OUT_COL_W-1:0] t_col;

    typedef struct packed {
        t_pix pixel;
        logic frame_start;
    } t_in_beat;

    typedef struct packed {
        t_pix edge_value;
        logic overflowed;
        logic border_pass;
        t_col out_column;
        logic last_of_run;
    } t_out_beat;

endpackage

// ===== design/sobel_edge_magnitude_3x3.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Depends on sobel_pkg and assert_macros.svh.
//
// This block takes one 8-bit grayscale pixel per clock in raster order and
// returns |Gx|+|Gy| of the standard Sobel kernels for every row that has a row
// above and below it, truncated to 8 bits with an overflow flag. The first and
// last columns of such a row pass the centre pixel through and are flagged as
// border beats; the first and last image rows give no results. A pixel with
// frame_start set, or any write of line_width, restarts the row and column
// counts. Widths outside 3..MAX_LINE_WIDTH are clamped. The block accepts one
// pixel every clock while the queue has room: the two line stores are single
// memories with one read and one write port each, read into registers when a
// pixel is accepted; the window and gradient are evaluated from those reads in
// stage one. A pixel's results enter the four-entry output queue when stage one
// advances. The last pixel of a row yields two results, so the output side sees
// at most one beat per cycle on average and the queue absorbs the extra beat;
// the input stalls only when the queue holds three or more results. The line
// stores hold no defined contents after reset and need no clearing pass; the
// restart rules keep every read that feeds a result on written data.

`include "assert_macros.svh"

module sobel_edge_magnitude_3x3 #(
    parameter int MAX_LINE_WIDTH = sobel_pkg::DEFAULT_MAX_LINE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sobel_pkg::LINE_WIDTH_W-1:0]   i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  sobel_pkg::t_in_beat                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output sobel_pkg::t_out_beat                 o_out_data
);
    import sobel_pkg::*;

    // Column address width, and a width that can hold the row length itself.
    localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;
    localparam int FIFO_DEPTH = 4;
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int QW = $clog2(FIFO_DEPTH + 1);

    // ---------------------------------------------------------------------
    // Configuration and row/column tracking.
    // ---------------------------------------------------------------------
    logic [LINE_WIDTH_W-1:0] r_line_width;
    logic [AW-1:0]           r_col;
    logic [1:0]              r_rows;

    logic [CW-1:0] lw_ext;
    logic [WW-1:0] eff_w;
    logic [WW-1:0] w_minus_1;
    logic [AW-1:0] c_sel;
    logic          c_is_last;
    logic [1:0]    rows_base;
    logic          accept;
    logic          s1_adv;

    assign accept = i_in_valid && o_in_ready;

    // Clamp the configured width to the supported range.
    always_comb begin
        lw_ext = CW'(r_line_width);
        if (lw_ext < CW'(3)) begin
            eff_w = WW'(3);
        end else if (lw_ext > CW'(MAX_LINE_WIDTH)) begin
            eff_w = WW'(MAX_LINE_WIDTH);
        end else begin
            eff_w = WW'(lw_ext);
        end
        w_minus_1 = eff_w - 1'b1;
    end

    // Column of the arriving pixel, after a frame restart or a stray count.
    always_comb begin
        if (i_in_data.frame_start || (WW'(r_col) >= eff_w)) begin
            c_sel = '0;
        end else begin
            c_sel = r_col;
        end
        c_is_last = (WW'(c_sel) == w_minus_1);
        rows_base = i_in_data.frame_start ? 2'd0 : r_rows;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_col        <= '0;
            r_rows       <= '0;
        end else if (i_cfg_we) begin
            // A width change always starts a fresh frame.
            r_line_width <= i_cfg_wdata;
            r_col        <= '0;
            r_rows       <= '0;
        end else if (accept) begin
            if (c_is_last) begin
                r_col  <= '0;
                r_rows <= (rows_base < 2'd2) ? rows_base + 2'd1 : rows_base;
            end else begin
                r_col  <= c_sel + 1'b1;
                r_rows <= rows_base;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Line stores. The middle store is read and rewritten with the new pixel
    // at acceptance. The upper store receives the middle value read out for
    // that column when stage one advances, so a same-address read is forwarded.
    // ---------------------------------------------------------------------
    t_pix r_upper [MAX_LINE_WIDTH];
    t_pix r_middle [MAX_LINE_WIDTH];

    logic          r_s1_valid;
    t_pix          r_s1_pix;
    logic [AW-1:0] r_s1_c;
    logic          r_s1_emit;
    logic          r_s1_last;
    t_pix          r_up_mem;
    t_pix          r_mid_rd;
    logic          r_up_fwd;
    t_pix          r_up_fwd_data;
    t_pix          up_rd;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_middle[c_sel] <= i_in_data.pixel;
            r_mid_rd        <= r_middle[c_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_upper[r_s1_c] <= r_mid_rd;
        end
        if (accept) begin
            r_up_mem <= r_upper[c_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_fwd      <= s1_adv && (r_s1_c == c_sel);
            r_up_fwd_data <= r_mid_rd;
            r_s1_pix      <= i_in_data.pixel;
            r_s1_c        <= c_sel;
            r_s1_emit     <= (rows_base >= 2'd2);
            r_s1_last     <= c_is_last;
        end
    end

    assign up_rd = r_up_fwd ? r_up_fwd_data : r_up_mem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Window and gradient. The window shifts left by one column for every
    // pixel; the right column takes upper, middle and the new pixel.
    // ---------------------------------------------------------------------
    t_pix r_win [9];
    t_pix n_win [9];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3 + 0] = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = up_rd;
        n_win[5] = r_mid_rd;
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_adv) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    logic [9:0]  gx_pos;
    logic [9:0]  gx_neg;
    logic [9:0]  gy_pos;
    logic [9:0]  gy_neg;
    logic [9:0]  gx_abs;
    logic [9:0]  gy_abs;
    logic [10:0] grad_sum;

    always_comb begin
        gx_pos = 10'(n_win[2]) + {1'b0, n_win[5], 1'b0} + 10'(n_win[8]);
        gx_neg = 10'(n_win[0]) + {1'b0, n_win[3], 1'b0} + 10'(n_win[6]);
        gy_pos = 10'(n_win[6]) + {1'b0, n_win[7], 1'b0} + 10'(n_win[8]);
        gy_neg = 10'(n_win[0]) + {1'b0, n_win[1], 1'b0} + 10'(n_win[2]);
        gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        grad_sum = 11'(gx_abs) + 11'(gy_abs);
    end

    // Up to two results per pixel: the interior value or, in the second column,
    // the left border pixel, and at the end of a row also the right border pixel.
    t_out_beat res0;
    t_out_beat res1;
    logic [1:0] n_push;

    always_comb begin
        res0   = '0;
        res1   = '0;
        n_push = 2'd0;
        if (r_s1_emit) begin
            if (r_s1_c == AW'(1)) begin
                res0.edge_value  = n_win[4];
                res0.border_pass = 1'b1;
                res0.out_column  = '0;
                res0.last_of_run = 1'b1;
                n_push           = 2'd1;
            end else if (r_s1_c >= AW'(2)) begin
                res0.edge_value  = grad_sum[7:0];
                res0.overflowed  = (grad_sum > 11'd255);
                res0.out_column  = t_col'(r_s1_c - 1'b1);
                res0.last_of_run = !r_s1_last;
                res1.edge_value  = n_win[5];
                res1.border_pass = 1'b1;
                res1.out_column  = t_col'(r_s1_c);
                res1.last_of_run = 1'b1;
                n_push           = r_s1_last ? 2'd2 : 2'd1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output queue. Stage one advances only when two free entries remain.
    // ---------------------------------------------------------------------
    t_out_beat     r_fifo [FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [QW-1:0] r_count;
    logic          pop;
    logic [PW-1:0] wr_ptr_1;

    assign s1_adv      = r_s1_valid && (r_count <= QW'(FIFO_DEPTH - 2));
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;
    assign wr_ptr_1    = r_wr_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            if (n_push != 2'd0) begin
                r_fifo[r_wr_ptr] <= res0;
            end
            if (n_push == 2'd2) begin
                r_fifo[wr_ptr_1] <= res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s1_adv) begin
                r_wr_ptr <= r_wr_ptr + PW'(n_push);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QW'(s1_adv ? n_push : 2'd0) - QW'(pop);
        end
    end

    // ---------------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------------
    `SOBEL_ASSERT_NEVER(a_fifo_overrun, r_count > QW'(FIFO_DEPTH), "output queue overrun")
    `SOBEL_ASSERT(a_stall_blocks_input, r_s1_valid && !s1_adv |-> !o_in_ready, "input taken during stall")
    `SOBEL_ASSERT(a_border_no_ovf, o_out_valid && o_out_data.border_pass |-> !o_out_data.overflowed, "border beat flagged overflow")
    `SOBEL_ASSERT(a_cfg_restarts, i_cfg_we |=> (r_rows == 2'd0) && (r_col == '0), "width write did not restart counts")

endmodule

// ===== bench/sobel_edge_magnitude_3x3_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_magnitude_3x3: a queue-fed pixel driver, a
// result monitor and a per-pixel Sobel predictor. Depends on sobel_pkg and the block.

module sobel_edge_magnitude_3x3_test;
    import sobel_pkg::*;

    localparam int MAX_W         = DEFAULT_MAX_LINE_WIDTH;
    // Settling time after draining, so that stray beats still show up.
    localparam int SETTLE_CYCLES = 8;
    // Cycles with work pending but no beat on either side before the run is abandoned.
    localparam int STALL_LIMIT   = 4000;
    localparam int PRINT_CAP     = 40;
    localparam int DIRECTED_LEN  = 24;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [LINE_WIDTH_W-1:0] cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    t_in_beat                in_data   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    t_out_beat               out_data;

    // Pixels waiting to be driven, and edge beats the predictor says are owed.
    t_in_beat  pixel_queue[$];
    t_out_beat edge_queue[$];

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Predictor state: the two stored rows, the 3x3 window and the raster position.
    logic [7:0]              row_above [MAX_W];
    logic [7:0]              row_mid   [MAX_W];
    logic [7:0]              win       [9];
    int unsigned             col_now;
    int unsigned             rows_filled;
    logic [LINE_WIDTH_W-1:0] width_raw;

    int unsigned n_mismatch     = 0;
    int unsigned n_checked      = 0;
    int unsigned n_pixels       = 0;
    int unsigned n_overflow     = 0;
    int unsigned n_border       = 0;
    int unsigned n_width_writes = 0;
    int unsigned stall_cycles   = 0;

    // Directed image at width 3: a vertical step that overflows the magnitude,
    // a solid row, a restart in the middle of a row, a flat frame that gives a
    // zero gradient, and one pixel left hanging so the next write lands mid-row.
    int directed_px [DIRECTED_LEN] = '{
        0, 0, 255,  0, 0, 255,  0, 0, 255,  255, 255, 255,
        255, 255,
        128, 128, 128,  128, 128, 128,  128, 128, 128,
        7
    };

    sobel_edge_magnitude_3x3 u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned used_width();
        if (width_raw < 3) return 3;
        if (width_raw > MAX_W) return MAX_W;
        return width_raw;
    endfunction

    function automatic void restore_reset_state();
        for (int k = 0; k < 9; k++) win[k] = '0;
        col_now     = 0;
        rows_filled = 0;
        width_raw   = LINE_WIDTH_RESET;
    endfunction

    // A width write restarts the raster position just as a frame start does.
    function automatic void apply_width(logic [LINE_WIDTH_W-1:0] raw);
        width_raw   = raw;
        col_now     = 0;
        rows_filled = 0;
    endfunction

    function automatic void owe_edge(logic [7:0] value, logic ovf, logic border,
                                     int unsigned col, logic last);
        t_out_beat b;
        b.edge_value  = value;
        b.overflowed  = ovf;
        b.border_pass = border;
        b.out_column  = t_col'(col);
        b.last_of_run = last;
        edge_queue.push_back(b);
    endfunction

    // Takes one accepted pixel through the window and queues the edge beats it
    // releases. Results always describe the row before the one arriving.
    function automatic void predict_pixel(t_in_beat px);
        int unsigned w;
        int unsigned c;
        int          gx;
        int          gy;
        int          mag;
        logic [7:0]  up;
        logic [7:0]  mid;
        w = used_width();
        if (px.frame_start) begin
            col_now     = 0;
            rows_filled = 0;
        end
        if (col_now >= w) col_now = 0;
        c   = col_now;
        up  = row_above[c];
        mid = row_mid[c];
        for (int r = 0; r < 3; r++) begin
            win[3*r]   = win[3*r+1];
            win[3*r+1] = win[3*r+2];
        end
        win[2]       = up;
        win[5]       = mid;
        win[8]       = px.pixel;
        row_above[c] = mid;
        row_mid[c]   = px.pixel;

        if (rows_filled >= 2) begin
            if (c == 1) begin
                // Column 0 of the finished row goes out untouched.
                owe_edge(win[4], 1'b0, 1'b1, 0, 1'b1);
            end else if (c >= 2) begin
                gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
                   - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
                gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
                   - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
                mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                owe_edge(mag[7:0], mag > 255, 1'b0, c - 1, c != w - 1);
                // The last pixel of a row also releases the right border column.
                if (c == w - 1) owe_edge(win[5], 1'b0, 1'b1, c, 1'b1);
            end
        end

        if (c == w - 1) begin
            col_now = 0;
            if (rows_filled < 2) rows_filled++;
        end else begin
            col_now = c + 1;
        end
    endfunction

    task automatic report_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= PRINT_CAP) $display("MISMATCH at beat %0d: %s", n_checked, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: one pixel beat at a time from the pending queue. Valid only
    // drops after a beat is taken, when the queue is empty or the sender idles.
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= pixel_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: tracks width writes and accepted pixels in the predictor,
    // checks each result beat against the oldest owed one, paces the
    // receiver and keeps the watchdog.
    // ------------------------------------------------------------------

    always @(posedge clk) begin : monitor
        t_out_beat want;
        logic      in_fire;
        logic      out_fire;
        in_fire  = in_valid && in_ready;
        out_fire = out_valid && out_ready;
        if (!rst_n) begin
            restore_reset_state();
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (cfg_we) apply_width(cfg_wdata);
            if (in_fire) begin
                predict_pixel(in_data);
                n_pixels++;
            end
            if (out_fire) begin
                if (edge_queue.size() == 0) begin
                    report_mismatch($sformatf("beat with nothing owed (edge_value %0d column %0d)",
                                              out_data.edge_value, out_data.out_column));
                end else begin
                    want = edge_queue.pop_front();
                    if (out_data.edge_value !== want.edge_value)
                        report_mismatch($sformatf("edge_value %0d, expected %0d",
                                                  out_data.edge_value, want.edge_value));
                    if (out_data.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed %0b, expected %0b",
                                                  out_data.overflowed, want.overflowed));
                    if (out_data.border_pass !== want.border_pass)
                        report_mismatch($sformatf("border_pass %0b, expected %0b",
                                                  out_data.border_pass, want.border_pass));
                    if (out_data.out_column !== want.out_column)
                        report_mismatch($sformatf("out_column %0d, expected %0d",
                                                  out_data.out_column, want.out_column));
                    if (out_data.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                  out_data.last_of_run, want.last_of_run));
                    if (want.overflowed) n_overflow++;
                    if (want.border_pass) n_border++;
                end
                n_checked++;
            end
            // Only cycles with work outstanding count toward the watchdog.
            if ((pixel_queue.size() != 0 || in_valid || edge_queue.size() != 0)
                    && !in_fire && !out_fire) begin
                stall_cycles++;
            end else begin
                stall_cycles = 0;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles, %0d results still owed",
                         STALL_LIMIT, edge_queue.size());
                $display("sobel_edge_magnitude_3x3_test NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_pixel(logic [7:0] value, logic restart);
        t_in_beat b;
        b.pixel       = value;
        b.frame_start = restart;
        pixel_queue.push_back(b);
    endfunction

    // Flavors of image content: noise, hard black and white, and values in a
    // narrow band that keep the magnitude small.
    function automatic logic [7:0] pick_pixel(int unsigned flavor);
        case (flavor)
            0: return 8'($urandom_range(255));
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            default: return 8'(100 + $urandom_range(20));
        endcase
    endfunction

    // Mostly small widths, with some raw values below the legal floor that
    // must act as three.
    function automatic logic [LINE_WIDTH_W-1:0] pick_width_raw();
        if ($urandom_range(9) < 2) return LINE_WIDTH_W'($urandom_range(2));
        return LINE_WIDTH_W'($urandom_range(3, 16));
    endfunction

    // Waits until no pixel is pending and every owed result has arrived. With
    // settle set it also lets pixels that owe nothing clear the pipeline.
    task automatic wait_drained(bit settle);
        do @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || edge_queue.size() != 0);
        if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_width(logic [LINE_WIDTH_W-1:0] raw);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= raw;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        n_width_writes++;
    endtask

    // Queues at least budget pixels. Most runs are whole frames that start with
    // frame_start and hold three to five rows; the rest are frames cut short and
    // noise runs where frame_start shows up anywhere in a row.
    task automatic queue_random_traffic(int unsigned budget);
        int unsigned w;
        int unsigned added;
        int unsigned kind;
        int unsigned flavor;
        int unsigned n;
        logic        restart;
        w     = used_width();
        added = 0;
        while (added < budget) begin
            kind   = $urandom_range(9);
            flavor = $urandom_range(2);
            if (kind < 7) n = w * $urandom_range(3, 5);
            else n = $urandom_range(1, 2 * w);
            for (int k = 0; k < n; k++) begin
                if (kind == 9) restart = ($urandom_range(7) == 0);
                else restart = (k == 0);
                queue_pixel(pick_pixel(flavor), restart);
            end
            added += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // At the reset width of 5000 a handful of pixels must give no result.
        for (int k = 0; k < 10; k++) queue_pixel(8'($urandom_range(255)), 1'b0);
        wait_drained(1);

        // Directed frame; a raw width of zero must act as three.
        write_width('0);
        for (int k = 0; k < DIRECTED_LEN; k++)
            queue_pixel(8'(directed_px[k]), k == 0 || k == 14);
        wait_drained(1);

        // Random frames under each pacing mix, two widths per mix. The last mix
        // also has the sender wait for every owed result halfway through.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 21 : 0;
            recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 21 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                write_width(pick_width_raw());
                queue_random_traffic(8);
                if (ph == 3) wait_drained(0);
                queue_random_traffic(8);
                wait_drained(1);
            end
        end

        $display("Drove %0d pixels and checked %0d result beats (%0d border, %0d overflowed)",
                 n_pixels, n_checked, n_border, n_overflow);
        $display("over %0d width writes, clamped small widths, restarts and stalls.",
                 n_width_writes);
        if (n_mismatch == 0) begin
            $display("sobel_edge_magnitude_3x3_test OK");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("sobel_edge_magnitude_3x3_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/sobel_pkg.sv
design/sobel_edge_magnitude_3x3.sv
bench/sobel_edge_magnitude_3x3_test.sv
